// ----- hw/rtl/sbt_pkg.sv -----
`timescale 1ns / 1ps

package sbt_pkg;

    localparam int NODE_COUNT = 64;
    localparam int CHUNK_BITS = 128;
    localparam int ADDR_W     = 64;
    localparam int POS_W      = $clog2(CHUNK_BITS);
    localparam int TAG_W      = ADDR_W - POS_W;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_TEST  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] bit_number;
    } in_word_t;

    typedef struct packed {
        logic status;
        logic bit_value;
    } out_word_t;

    // operation as broadcast to every cell
    typedef struct packed {
        logic [1:0]       cmd;
        logic [TAG_W-1:0] tag;
        logic [POS_W-1:0] pos;
    } op_t;

    // phase and global lookup result driven to every cell
    typedef struct packed {
        logic lookup;
        logic update;
        logic hit;
    } cell_ctl_t;

    // per-cell status back to the controller
    typedef struct packed {
        logic match;
        logic alloc;
        logic rd_bit;
    } cell_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

endpackage

// ----- hw/rtl/sbt_cell.sv -----
`timescale 1ns / 1ps

module sbt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sbt_pkg::op_t       op,
    input  sbt_pkg::cell_ctl_t ctl,
    input  logic               free_in,
    output logic               free_out,
    output sbt_pkg::cell_stat_t stat
);
    import sbt_pkg::*;

    logic                  valid_reg, valid_next;
    logic                  match_reg, match_next;
    logic                  alloc_reg, alloc_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [CHUNK_BITS-1:0] chunk_reg, chunk_next;
    logic [CHUNK_BITS-1:0] mask;
    logic [CHUNK_BITS-1:0] cleared;

    // free-node prefix: high once this or any lower-numbered cell is free
    assign free_out = free_in | ~valid_reg;

    assign mask    = CHUNK_BITS'(1) << op.pos;
    assign cleared = chunk_reg & ~mask;

    always_comb
    begin
        valid_next = valid_reg;
        match_next = match_reg;
        alloc_next = alloc_reg;
        tag_next   = tag_reg;
        chunk_next = chunk_reg;
        if (ctl.lookup)
        begin
            match_next = valid_reg && (tag_reg == op.tag);
            alloc_next = ~valid_reg & ~free_in;
        end
        if (ctl.update)
        begin
            case (op.cmd)
                CMD_SET:
                begin
                    if (match_reg)
                    begin
                        chunk_next = chunk_reg | mask;
                    end
                    else if (!ctl.hit && alloc_reg)
                    begin
                        valid_next = 1'b1;
                        tag_next   = op.tag;
                        chunk_next = mask;
                    end
                end
                CMD_CLEAR:
                begin
                    if (match_reg)
                    begin
                        chunk_next = cleared;
                        if (cleared == '0)
                        begin
                            valid_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            alloc_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            alloc_reg <= alloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        chunk_reg <= chunk_next;
    end

    assign stat.match  = match_reg;
    assign stat.alloc  = alloc_reg;
    assign stat.rd_bit = match_reg & chunk_reg[op.pos];

endmodule

// ----- hw/rtl/sparse_bitmap_table.sv -----
`timescale 1ns / 1ps
// Channel   Ports                    Handshake
// -------   ----------------------   ---------------------------------------
// command   start, busy, request     word taken when start && !busy
// result    done, result             one-cycle strobe, receiver always takes
//
// Busy stays high while a word is worked on. First comes the lookup cycle: tag
// compare in every cell and the free-node prefix along the cell row. The
// update cycle then does the read-modify-write of the chunk in the matching
// or allocated cell. The result strobe comes in the next cycle with busy low.
// A new word can be taken at the edge that ends that cycle, not earlier. The
// receiver cannot stall, so nothing else holds input. Reset empties the table
// at once: only the per-cell valid, match and alloc bits are cleared.
module sparse_bitmap_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sbt_pkg::in_word_t  request,
    output logic               done,
    output sbt_pkg::out_word_t result
);
    import sbt_pkg::*;

    state_t     state_reg, state_next;
    in_word_t   req_reg, req_next;
    logic       free_any_reg, free_any_next;
    logic       done_reg, done_next;
    out_word_t  result_reg, result_next;

    op_t        op;
    cell_ctl_t  ctl;
    cell_stat_t stat [NODE_COUNT];
    logic       free_chain [NODE_COUNT+1];

    logic [NODE_COUNT-1:0] match_vec;
    logic [NODE_COUNT-1:0] alloc_vec;
    logic [NODE_COUNT-1:0] rd_vec;
    logic                  hit_any;

    logic accept;

    assign accept = start && (state_reg == ST_IDLE);

    // tag is the upper bits of the bit number, pos the offset in the chunk
    assign op.cmd = req_reg.cmd;
    assign op.tag = req_reg.bit_number[ADDR_W-1:POS_W];
    assign op.pos = req_reg.bit_number[POS_W-1:0];

    // row of cells; the free chain ripples from node 0 upward so the
    // lowest-numbered free node sees no free node before it
    assign free_chain[0] = 1'b0;

    for (genvar i = 0; i < NODE_COUNT; i++)
    begin : g_cell
        sbt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (op),
            .ctl      (ctl),
            .free_in  (free_chain[i]),
            .free_out (free_chain[i+1]),
            .stat     (stat[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            match_vec[i] = stat[i].match;
            alloc_vec[i] = stat[i].alloc;
            rd_vec[i]    = stat[i].rd_bit;
        end
    end

    assign hit_any = |match_vec;

    assign ctl.lookup = (state_reg == ST_LOOKUP);
    assign ctl.update = (state_reg == ST_UPDATE);
    assign ctl.hit    = hit_any;

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        free_any_next = free_any_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = request;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // table state is stable here, so the chain end is final
                free_any_next = free_chain[NODE_COUNT];
                state_next    = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // set with no matching node and no free node: no space
                result_next.status    = (req_reg.cmd == CMD_SET) && !hit_any
                                        && !free_any_reg;
                result_next.bit_value = (req_reg.cmd == CMD_TEST) && (|rd_vec);
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        free_any_reg <= free_any_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a tag lives in at most one node
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one node matches the tag");

    // at most one node is picked for allocation
    a_alloc_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(alloc_vec))
        else $error("more than one node picked for allocation");

    // a result strobe only follows an update cycle
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_UPDATE))
        else $error("result strobe without update");

    // no-space status only comes from a set
    a_status_set_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status) |-> (req_reg.cmd == CMD_SET))
        else $error("no-space status on a command other than set");

    // an accepted word goes to lookup next
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted word did not enter lookup");

endmodule
